// File: sv/dllp_pkg.sv
// Shared types, codes and helpers for the directory listing line parser.
// No dependencies; used by dllp_ctrl, dllp_dp and the top level.
package dllp_pkg;

  localparam int NAME_CHARS = 16;
  localparam int ID_CHARS   = 5;
  localparam int MIN_TEXT   = 5;

  localparam logic [7:0] SHIFT_SPACE = 8'hA0;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_B        = 8'h62;

  localparam logic [23:0] TAIL_PRG = "prg";
  localparam logic [23:0] TAIL_SEQ = "seq";
  localparam logic [23:0] TAIL_USR = "usr";
  localparam logic [23:0] TAIL_DEL = "del";
  localparam logic [23:0] TAIL_REL = "rel";
  localparam logic [23:0] TAIL_CBM = "cbm";
  localparam logic [23:0] TAIL_DIR = "dir";
  localparam logic [23:0] TAIL_VRP = "vrp";
  localparam logic [23:0] TAIL_LNK = "lnk";

  typedef enum logic [2:0] {
    ST_OK, ST_END, ST_TEXT_ERR, ST_SHORT, ST_DEV_ERR
  } status_t;

  typedef enum logic [3:0] {
    TY_DEL, TY_CBM, TY_DIR, TY_LNK, TY_HEADER, TY_SEQ,
    TY_PRG, TY_USR, TY_REL, TY_VRP, TY_FREE
  } ftype_t;

  typedef enum logic [1:0] {
    KIND_NONE, KIND_NAME, KIND_ID
  } kind_t;

  typedef struct packed {
    logic    size_lo;
    logic    size_hi;
    logic    line_start;
    logic    store;
    logic    fin_init;
    logic    name_wr;
    logic    pos_inc;
    logic    id_init;
    logic    id_wr;
    logic    strip_step;
    logic    emit;
    logic    single;
    status_t st;
    logic    use_size;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic err_bit;
    logic first_b;
    logic short_line;
    logic is_header;
    logic pos_end;
    logic n_full;
    logic id_last;
    logic eff_quote;
    logic eff_space;
    logic strip_blank;
    logic k_one;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h00) || (b == CH_SPACE) || (b == SHIFT_SPACE);
  endfunction

  function automatic ftype_t tail_type(input logic [23:0] t);
    ftype_t r;
    if (t == TAIL_PRG) r = TY_PRG;
    else if (t == TAIL_SEQ) r = TY_SEQ;
    else if (t == TAIL_USR) r = TY_USR;
    else if (t == TAIL_DEL) r = TY_DEL;
    else if (t == TAIL_REL) r = TY_REL;
    else if (t == TAIL_CBM) r = TY_CBM;
    else if (t == TAIL_DIR) r = TY_DIR;
    else if (t == TAIL_VRP) r = TY_VRP;
    else if (t == TAIL_LNK) r = TY_LNK;
    else r = TY_HEADER;
    return r;
  endfunction

endpackage

// File: sv/dllp_dp.sv
// Datapath: line store memory, line bookkeeping, name/id registers, output register.
// Depends on dllp_pkg; driven by dllp_ctrl commands.
module dllp_dp #(
  parameter int LINE_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  logic             read_error,
  input  dllp_pkg::cmd_t   cmd,
  output dllp_pkg::stat_t  stat,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [2:0]       status,
  output logic [15:0]      block_count,
  output logic [3:0]       file_type,
  output logic [1:0]       char_kind,
  output logic [3:0]       char_index,
  output logic [7:0]       char_value,
  output logic             last
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 1);
  localparam int PW = $clog2(LINE_BYTES + dllp_pkg::NAME_CHARS + dllp_pkg::ID_CHARS + 4);

  logic [7:0]    mem [LINE_BYTES];
  logic [7:0]    rd;
  logic [15:0]   size;
  logic [CW-1:0] count;
  logic [CW-1:0] len;
  logic [7:0]    sh0, sh1, t0, t1, t2, first;
  logic          qfound;
  logic [AW-1:0] qpos;
  logic [PW-1:0] pos;
  logic [4:0]    n;
  logic [3:0]    k;
  logic [4:0]    e;
  logic [7:0]    name [dllp_pkg::NAME_CHARS];
  logic [7:0]    id [dllp_pkg::ID_CHARS];
  dllp_pkg::ftype_t ty;

  logic          can_store;
  logic [7:0]    effv;
  logic [4:0]    e_id;
  logic [7:0]    emit_val;

  assign can_store = count < CW'(LINE_BYTES);
  assign effv      = (PW'(len) > pos) ? rd : 8'h00;
  assign e_id      = e - 5'(dllp_pkg::NAME_CHARS);
  assign emit_val  = (e < 5'(dllp_pkg::NAME_CHARS)) ? name[e[3:0]] : id[e_id[2:0]];

  assign stat.byte_zero   = data_byte == 8'h00;
  assign stat.err_bit     = read_error;
  assign stat.first_b     = first == dllp_pkg::CH_B;
  assign stat.short_line  = count < CW'(dllp_pkg::MIN_TEXT);
  assign stat.is_header   = ty == dllp_pkg::TY_HEADER;
  assign stat.pos_end     = pos >= PW'(LINE_BYTES);
  assign stat.n_full      = n == 5'(dllp_pkg::NAME_CHARS);
  assign stat.id_last     = n == 5'(dllp_pkg::ID_CHARS - 1);
  assign stat.eff_quote   = effv == dllp_pkg::CH_QUOTE;
  assign stat.eff_space   = effv == dllp_pkg::CH_SPACE;
  assign stat.strip_blank = dllp_pkg::is_blank(name[k]);
  assign stat.k_one       = k == 4'd1;
  assign stat.emit_last   = (ty == dllp_pkg::TY_HEADER)
                            ? (e == 5'(dllp_pkg::NAME_CHARS + dllp_pkg::ID_CHARS - 1))
                            : (e == 5'(dllp_pkg::NAME_CHARS - 1));
  assign stat.out_free    = !out_valid || out_ready;

  // line store: one write port for text, one registered read port at pos
  always_ff @(posedge clk) begin
    if (cmd.store && can_store) begin
      mem[count[AW-1:0]] <= data_byte;
    end
    rd <= mem[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size  <= '0;
      count <= '0;
      len   <= '0;
      first <= '0;
      for (int i = 0; i < dllp_pkg::ID_CHARS; i++) id[i] <= '0;
    end else begin
      if (cmd.size_lo) size <= {8'h00, data_byte};
      if (cmd.size_hi) size <= {data_byte, size[7:0]};
      if (cmd.line_start) begin
        count  <= '0;
        len    <= '0;
        first  <= '0;
        sh0    <= '0;
        sh1    <= '0;
        qfound <= 1'b0;
      end
      if (cmd.store && can_store) begin
        count <= count + 1'b1;
        sh0   <= data_byte;
        sh1   <= sh0;
        if (count == '0) first <= data_byte;
        // trailing blanks never count: len tracks the last non-blank byte
        if (!dllp_pkg::is_blank(data_byte)) begin
          len <= count + 1'b1;
          t0  <= sh1;
          t1  <= sh0;
          t2  <= data_byte;
        end
        if (data_byte == dllp_pkg::CH_QUOTE && !qfound) begin
          qfound <= 1'b1;
          qpos   <= count[AW-1:0];
        end
      end
      if (cmd.fin_init) begin
        for (int i = 0; i < dllp_pkg::NAME_CHARS; i++) name[i] <= '0;
        n <= '0;
        e <= '0;
        pos <= qfound ? (PW'(qpos) + 1'b1) : PW'(LINE_BYTES + 1);
        if (stat.first_b) ty <= dllp_pkg::TY_FREE;
        else if (len >= CW'(3)) ty <= dllp_pkg::tail_type({t0, t1, t2});
        else ty <= dllp_pkg::TY_HEADER;
      end
      if (cmd.name_wr) begin
        name[n[3:0]] <= effv;
        n   <= n + 1'b1;
        pos <= pos + 1'b1;
      end
      if (cmd.pos_inc) pos <= pos + 1'b1;
      if (cmd.id_init) begin
        n <= '0;
        k <= 4'(dllp_pkg::NAME_CHARS - 1);
      end
      if (cmd.id_wr) begin
        if (effv != 8'h00) id[n[2:0]] <= effv;
        n   <= n + 1'b1;
        pos <= pos + 1'b1;
      end
      if (cmd.strip_step) begin
        name[k] <= '0;
        k <= k - 1'b1;
      end
      if (cmd.emit) e <= e + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.single) begin
      out_valid   <= 1'b1;
      status      <= cmd.st;
      block_count <= cmd.use_size ? size : 16'h0000;
      file_type   <= dllp_pkg::TY_DEL;
      char_kind   <= dllp_pkg::KIND_NONE;
      char_index  <= '0;
      char_value  <= '0;
      last        <= 1'b1;
    end else if (cmd.emit) begin
      out_valid   <= 1'b1;
      status      <= dllp_pkg::ST_OK;
      block_count <= size;
      file_type   <= ty;
      if (e < 5'(dllp_pkg::NAME_CHARS)) begin
        char_kind  <= dllp_pkg::KIND_NAME;
        char_index <= e[3:0];
      end else begin
        char_kind  <= dllp_pkg::KIND_ID;
        char_index <= e_id[3:0];
      end
      char_value  <= emit_val;
      last        <= stat.emit_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LINE_BYTES)) else $error("text count past line size");
  a_len_le_count: assert property (@(posedge clk) disable iff (rst)
    len <= count) else $error("stripped length beyond text count");
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.single)) else $error("two result loads in one cycle");
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> e < 5'(dllp_pkg::NAME_CHARS + dllp_pkg::ID_CHARS))
    else $error("emit index out of range");

endmodule

// File: sv/dllp_ctrl.sv
// Controller: line phase and end-of-line scan sequencing.
// Depends on dllp_pkg; commands dllp_dp.
module dllp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dllp_pkg::stat_t stat,
  output dllp_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_LINK0, S_LINK1, S_CLO, S_CHI, S_TEXT, S_FIN, S_ONE,
    S_NRD, S_NEV, S_QRD, S_QEV, S_SRD, S_SEV, S_IRD, S_IEV, S_STRIP, S_EMIT
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign in_ready = stat.out_free &&
                    (state == S_LINK0 || state == S_LINK1 || state == S_CLO ||
                     state == S_CHI || state == S_TEXT);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.st     = dllp_pkg::ST_OK;
    state_next = state;
    case (state)
      S_LINK0: if (acc) begin
        if (stat.byte_zero) begin
          cmd.single = 1'b1;
          cmd.st     = dllp_pkg::ST_END;
        end else if (stat.err_bit) begin
          cmd.single = 1'b1;
          cmd.st     = dllp_pkg::ST_DEV_ERR;
        end else begin
          state_next = S_LINK1;
        end
      end
      S_LINK1: if (acc) state_next = S_CLO;
      S_CLO: if (acc) begin
        cmd.size_lo = 1'b1;
        state_next  = S_CHI;
      end
      S_CHI: if (acc) begin
        cmd.size_hi    = 1'b1;
        cmd.line_start = 1'b1;
        state_next     = S_TEXT;
      end
      S_TEXT: if (acc) begin
        if (stat.byte_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.store = 1'b1;
          if (stat.err_bit) begin
            cmd.single   = 1'b1;
            cmd.st       = dllp_pkg::ST_TEXT_ERR;
            cmd.use_size = 1'b1;
            state_next   = S_LINK0;
          end
        end
      end
      S_FIN: begin
        cmd.fin_init = 1'b1;
        if (stat.first_b) state_next = S_EMIT;
        else if (stat.short_line) state_next = S_ONE;
        else state_next = S_NRD;
      end
      S_ONE: if (stat.out_free) begin
        cmd.single   = 1'b1;
        cmd.st       = dllp_pkg::ST_SHORT;
        cmd.use_size = 1'b1;
        state_next   = S_LINK0;
      end
      S_NRD: begin
        if (stat.pos_end || stat.n_full) state_next = stat.is_header ? S_QRD : S_EMIT;
        else state_next = S_NEV;
      end
      S_NEV: begin
        if (stat.eff_quote) begin
          state_next = stat.is_header ? S_QRD : S_EMIT;
        end else begin
          cmd.name_wr = 1'b1;
          state_next  = S_NRD;
        end
      end
      S_QRD: state_next = S_QEV;
      S_QEV: begin
        cmd.pos_inc = stat.eff_quote;
        state_next  = S_SRD;
      end
      S_SRD: state_next = S_SEV;
      S_SEV: begin
        cmd.pos_inc = stat.eff_space;
        cmd.id_init = 1'b1;
        state_next  = S_IRD;
      end
      S_IRD: state_next = S_IEV;
      S_IEV: begin
        cmd.id_wr  = 1'b1;
        state_next = stat.id_last ? S_STRIP : S_IRD;
      end
      S_STRIP: begin
        if (stat.strip_blank) begin
          cmd.strip_step = 1'b1;
          if (stat.k_one) state_next = S_EMIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: if (stat.out_free) begin
        cmd.emit = 1'b1;
        if (stat.emit_last) state_next = S_LINK0;
      end
      default: state_next = S_LINK0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LINK0;
    end else begin
      state <= state_next;
    end
  end

  a_no_take_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_NRD || state == S_NEV || state == S_EMIT) |-> !in_ready)
    else $error("input taken during line scan");
  a_text_after_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEXT) |-> ($past(state) == S_CHI || $past(state) == S_TEXT))
    else $error("text phase entered out of order");
  a_emit_after_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_init |=> state != S_FIN) else $error("finish stuck");

endmodule

// File: sv/directory_listing_line_parser_top.sv
// Directory listing line parser: takes a BASIC-form directory listing one byte per
// beat and, at each line end, gives status, block count, file type and the name and
// disk id characters, one result per beat; an end marker, a device error or a text
// error gives a single status beat. A byte is taken only in the link, count and text
// phases and while the output register is free. At a line end the block scans the
// stored line through its single registered read port, with a read step and an
// evaluate step per name position. A header line then skips the closing quote and a
// space, reads the disk id and trims trailing blanks from the name; a short or
// blocks-free line skips the scan. Then 1, 16 or 21 result beats follow, one per
// cycle while the output is taken; input waits until the last is loaded.
// Depends on dllp_pkg, dllp_ctrl and dllp_dp.
module directory_listing_line_parser_top #(
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        read_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] block_count,
  output logic [3:0]  file_type,
  output logic [1:0]  char_kind,
  output logic [3:0]  char_index,
  output logic [7:0]  char_value,
  output logic        last
);

  dllp_pkg::cmd_t  cmd;
  dllp_pkg::stat_t stat;

  dllp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dllp_dp #(.LINE_BYTES(LINE_BYTES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .read_error  (read_error),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .block_count (block_count),
    .file_type   (file_type),
    .char_kind   (char_kind),
    .char_index  (char_index),
    .char_value  (char_value),
    .last        (last)
  );

endmodule

// File: verif/directory_listing_line_parser_top_tb.sv
// Self-checking testbench for directory_listing_line_parser_top.
// Holds a scoreboard class with its own line parser predictor; depends on dllp_pkg.
`timescale 1ns / 1ps

module directory_listing_line_parser_top_tb;

  localparam int STORE_BYTES = 128;

  typedef logic [7:0] bytes_q_t[$];

  typedef struct packed {
    dllp_pkg::status_t st;
    logic [15:0]       cnt;
    dllp_pkg::ftype_t  ty;
    dllp_pkg::kind_t   kind;
    logic [3:0]        idx;
    logic [7:0]        val;
    logic              last;
  } entry_t;

  class listing_scoreboard;
    entry_t      pending[$];
    int          mismatches;
    logic [2:0]  phase;
    logic [15:0] blocks;
    int          text_len;
    logic [7:0]  line_mem[STORE_BYTES];
    logic [7:0]  disk_id[dllp_pkg::ID_CHARS];

    function new();
      mismatches = 0;
      phase = 0;
      blocks = 0;
      text_len = 0;
      foreach (line_mem[j]) line_mem[j] = 0;
      foreach (disk_id[j]) disk_id[j] = 0;
    endfunction

    function void push(dllp_pkg::status_t st, logic [15:0] cnt, dllp_pkg::ftype_t ty,
                       dllp_pkg::kind_t kind, int idx, logic [7:0] val, logic last);
      entry_t e;
      e.st = st; e.cnt = cnt; e.ty = ty; e.kind = kind;
      e.idx = idx[3:0]; e.val = val; e.last = last;
      pending.push_back(e);
    endfunction

    // byte j of the line once trailing blanks are gone
    function logic [7:0] stripped(int j, int len);
      if (j >= len || j >= STORE_BYTES) return 8'h00;
      return line_mem[j];
    endfunction

    function void close_line();
      logic [7:0]       name[dllp_pkg::NAME_CHARS];
      logic [23:0]      tail;
      logic [7:0]       v;
      int               len, i, n;
      dllp_pkg::ftype_t ty;
      foreach (name[j]) name[j] = 0;
      if (line_mem[0] == dllp_pkg::CH_B) begin
        ty = dllp_pkg::TY_FREE;
      end else if (text_len < dllp_pkg::MIN_TEXT) begin
        push(dllp_pkg::ST_SHORT, blocks, dllp_pkg::TY_DEL, dllp_pkg::KIND_NONE, 0, 0, 1);
        return;
      end else begin
        len = text_len;
        while (len > 0 && (line_mem[len-1] == dllp_pkg::CH_SPACE ||
                           line_mem[len-1] == dllp_pkg::SHIFT_SPACE ||
                           line_mem[len-1] == 8'h00))
          len--;
        i = 0;
        while (i < STORE_BYTES && stripped(i, len) != dllp_pkg::CH_QUOTE) i++;
        i++;
        n = 0;
        while (i < STORE_BYTES && stripped(i, len) != dllp_pkg::CH_QUOTE &&
               n < dllp_pkg::NAME_CHARS) begin
          name[n] = stripped(i, len);
          n++;
          i++;
        end
        tail = (len < 3) ? 24'h0 : {line_mem[len-3], line_mem[len-2], line_mem[len-1]};
        case (tail)
          dllp_pkg::TAIL_PRG: ty = dllp_pkg::TY_PRG;
          dllp_pkg::TAIL_SEQ: ty = dllp_pkg::TY_SEQ;
          dllp_pkg::TAIL_USR: ty = dllp_pkg::TY_USR;
          dllp_pkg::TAIL_DEL: ty = dllp_pkg::TY_DEL;
          dllp_pkg::TAIL_REL: ty = dllp_pkg::TY_REL;
          dllp_pkg::TAIL_CBM: ty = dllp_pkg::TY_CBM;
          dllp_pkg::TAIL_DIR: ty = dllp_pkg::TY_DIR;
          dllp_pkg::TAIL_VRP: ty = dllp_pkg::TY_VRP;
          dllp_pkg::TAIL_LNK: ty = dllp_pkg::TY_LNK;
          default:            ty = dllp_pkg::TY_HEADER;
        endcase
        if (ty == dllp_pkg::TY_HEADER) begin
          if (stripped(i, len) == dllp_pkg::CH_QUOTE) i++;
          if (stripped(i, len) == dllp_pkg::CH_SPACE) i++;
          for (n = 0; n < dllp_pkg::ID_CHARS; n++) begin
            v = stripped(i, len);
            if (v != 0) disk_id[n] = v;
            i++;
          end
          // header name drops trailing blanks, first char always kept
          for (n = dllp_pkg::NAME_CHARS - 1; n > 0; n--) begin
            if (name[n] == 8'h00 || name[n] == dllp_pkg::CH_SPACE ||
                name[n] == dllp_pkg::SHIFT_SPACE)
              name[n] = 0;
            else
              break;
          end
        end
      end
      for (n = 0; n < dllp_pkg::NAME_CHARS; n++)
        push(dllp_pkg::ST_OK, blocks, ty, dllp_pkg::KIND_NAME, n, name[n],
             ty != dllp_pkg::TY_HEADER && n == dllp_pkg::NAME_CHARS - 1);
      if (ty == dllp_pkg::TY_HEADER)
        for (n = 0; n < dllp_pkg::ID_CHARS; n++)
          push(dllp_pkg::ST_OK, blocks, ty, dllp_pkg::KIND_ID, n, disk_id[n],
               n == dllp_pkg::ID_CHARS - 1);
    endfunction

    function void note_byte(logic [7:0] b, logic err);
      case (phase)
        0: begin
          if (b == 0)
            push(dllp_pkg::ST_END, 0, dllp_pkg::TY_DEL, dllp_pkg::KIND_NONE, 0, 0, 1);
          else if (err)
            push(dllp_pkg::ST_DEV_ERR, 0, dllp_pkg::TY_DEL, dllp_pkg::KIND_NONE, 0, 0, 1);
          else phase = 1;
        end
        1: phase = 2;
        2: begin
          blocks = {8'h00, b};
          phase = 3;
        end
        3: begin
          blocks[15:8] = b;
          foreach (line_mem[j]) line_mem[j] = 0;
          text_len = 0;
          phase = 4;
        end
        4: begin
          if (b == 0) begin
            phase = 0;
            close_line();
          end else begin
            if (text_len < STORE_BYTES) begin
              line_mem[text_len] = b;
              text_len++;
            end
            if (err) begin
              phase = 0;
              push(dllp_pkg::ST_TEXT_ERR, blocks, dllp_pkg::TY_DEL, dllp_pkg::KIND_NONE,
                   0, 0, 1);
            end
          end
        end
        default: phase = 0;
      endcase
    endfunction

    function void check_result(entry_t got);
      entry_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [7:0]  data_byte;
  logic        read_error;
  logic [2:0]  status;
  logic [15:0] block_count;
  logic [3:0]  file_type;
  logic [1:0]  char_kind;
  logic [3:0]  char_index;
  logic [7:0]  char_value;
  logic        last;

  listing_scoreboard sb;
  int burst_left;
  int bytes_sent;
  logic [7:0] stall_pat;

  directory_listing_line_parser_top DUT (.*);

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: rotating stall pattern, reseeded now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0)
      stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
    else
      stall_pat = {stall_pat[6:0], stall_pat[7]};
    out_ready = stall_pat[0] | rst;
  end

  always @(posedge clk) begin
    entry_t r;
    if (!rst && out_valid && out_ready) begin
      r.st = dllp_pkg::status_t'(status); r.cnt = block_count;
      r.ty = dllp_pkg::ftype_t'(file_type);
      r.kind = dllp_pkg::kind_t'(char_kind); r.idx = char_index; r.val = char_value;
      r.last = last;
      sb.check_result(r);
    end
  end

  task automatic send_byte(logic [7:0] b, logic err);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1;
    data_byte = b;
    read_error = err;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, err);
    bytes_sent++;
    @(negedge clk);
  endtask

  // err_at >= 0 flags that text byte and stops the line there
  task automatic send_line(bytes_q_t text, logic [15:0] size, int err_at);
    send_byte(8'($urandom_range(1, 255)), 0);
    send_byte(8'($urandom), 1'($urandom));
    send_byte(size[7:0], 1'($urandom));
    send_byte(size[15:8], 1'($urandom));
    foreach (text[j]) begin
      send_byte(text[j], j == err_at);
      if (j == err_at) return;
    end
    send_byte(8'h00, 1'($urandom));
  endtask

  function automatic bytes_q_t str_bytes(string s);
    bytes_q_t q;
    for (int j = 0; j < s.len(); j++) q.push_back(s[j]);
    return q;
  endfunction

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // mostly listing-shaped text with random content
  function automatic bytes_q_t random_text();
    bytes_q_t q;
    string kinds[9] = '{"prg", "seq", "usr", "del", "rel", "cbm", "dir", "vrp", "lnk"};
    int pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(0, 150)) q.push_back(any_nonzero());
      return q;
    end
    if (pick == 1) return str_bytes($sformatf("blocks free.%0d", $urandom_range(0, 99)));
    repeat ($urandom_range(0, 3)) q.push_back(dllp_pkg::CH_SPACE);
    if ($urandom_range(0, 9) != 0) q.push_back(dllp_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 18)) begin
      logic [7:0] c = 8'($urandom_range(32, 255));
      if (c == dllp_pkg::CH_QUOTE) c = 8'h41;
      if ($urandom_range(0, 5) == 0)
        c = ($urandom_range(0, 1)) ? dllp_pkg::CH_SPACE : dllp_pkg::SHIFT_SPACE;
      q.push_back(c);
    end
    if ($urandom_range(0, 9) != 0) q.push_back(dllp_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 3)) q.push_back(dllp_pkg::CH_SPACE);
    if (pick <= 3) begin
      // header: disk id after the name
      repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(33, 126)));
    end else begin
      q = {q, str_bytes(kinds[$urandom_range(0, 8)])};
      if ($urandom_range(0, 4) == 0) q.push_back(8'h3c);
    end
    repeat ($urandom_range(0, 2))
      q.push_back($urandom_range(0, 1) ? dllp_pkg::CH_SPACE : dllp_pkg::SHIFT_SPACE);
    return q;
  endfunction

  initial begin
    bytes_q_t t;
    int wait_cycles;
    sb = new();
    rst = 1;
    in_valid = 0;
    data_byte = 0;
    read_error = 0;
    out_ready = 1;
    stall_pat = 8'hFF;
    burst_left = 0;
    bytes_sent = 0;
    repeat (10) @(negedge clk);
    rst = 0;

    // directed
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_line(str_bytes("\"disk  \" ab 2a"), 16'h0000, -1);
    send_line(str_bytes("\"x\" id"), 16'hFFFF, -1);
    send_line(str_bytes("\"name\" prg"), 16'h1234, -1);
    send_line(str_bytes("\"sub\" dir"), 5, -1);
    send_line(str_bytes("blocks free."), 664, -1);
    send_line(str_bytes("\"ab"), 9, -1);
    send_line(str_bytes("\"abcdefghijklmnopqrst\" prg"), 11, -1);
    send_line(str_bytes("\"name\" prg"), 12, 3);
    t = str_bytes("\"long\" ");
    repeat (122) t.push_back(8'hFF);
    t = {t, str_bytes("prg")};
    send_line(t, 13, -1);
    t = str_bytes("\"a");
    repeat (14) t.push_back(dllp_pkg::SHIFT_SPACE);
    t = {t, str_bytes("\"\"xy")};
    send_line(t, 14, -1);
    t = str_bytes("  ");
    t.push_back(dllp_pkg::SHIFT_SPACE);
    send_line(t, 15, -1);

    // hold off until the block has drained
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    // random
    while (bytes_sent < 400) begin
      case ($urandom_range(0, 19))
        0: send_byte(8'h00, 1'($urandom));
        1: send_byte(any_nonzero(), 1);
        2: begin
          t = random_text();
          send_line(t, 16'($urandom), (t.size() > 0) ? $urandom_range(0, t.size() - 1) : -1);
        end
        default: send_line(random_text(), 16'($urandom), -1);
      endcase
    end
    in_valid = 0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (400) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
